// ----- design/hdsu_pkg.sv -----
// Shared types and constants for the half-duplex single-wire UART.
`default_nettype none
package hdsu_pkg;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int GUARD_W     = 6;
	localparam int DATA_W      = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SAMPLE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GUARD_BITS   = 2'd2;

	localparam logic [CFG_DATA_W-1:0] BIT_PERIOD_RST   = 16'd16;
	localparam logic [CFG_DATA_W-1:0] FIRST_SAMPLE_RST = 16'd24;
	localparam logic [GUARD_W-1:0]    GUARD_BITS_RST   = 6'd20;

	localparam logic [3:0] RX_STOP_SLOT = 4'd8;
	localparam logic [5:0] TX_LAST_BIT  = 6'd7;

	typedef struct packed {
		logic              line_in;
		logic              send_request;
		logic [DATA_W-1:0] send_data;
		logic              read_request;
	} tick_t;

	typedef struct packed {
		logic              line_drive;
		logic              line_level;
		logic              rx_ready;
		logic [DATA_W-1:0] rx_data;
		logic              send_accepted;
		logic              link_busy;
	} result_t;

endpackage
`default_nettype wire

// ----- design/half_duplex_soft_uart.sv -----
// Half-duplex single-wire 8N1 UART: one tick per beat, registered result.
//
// Usage:
//   tick channel: one beat per sampler tick carrying the sampled line level,
//   a send request with its byte and a read request for the one-byte buffer.
//   result channel: one beat per tick with line drive/level, buffer status and
//   data (as seen before that tick's read), send acceptance and busy flag.
//   Config port: cfg_write with cfg_index/cfg_data sets bit period, first
//   sample delay and guard length; write only while the link is quiet.
// Timing:
//   A tick beat updates the frame state in the cycle it is taken; its result
//   is held in the output register and shows in the next cycle. One tick per
//   cycle is sustained: tick_ready stays high while the result register is
//   empty or being drained, so the result register is the only limit.
// Reset:
//   arst_n clears both frame engines, the buffer and the result valid flag and
//   reloads the default timing registers.
// Stall:
//   While result_ready is low and a result waits, tick_ready drops and the
//   frame state holds until the waiting beat is taken.
`default_nettype none
module half_duplex_soft_uart #(
	parameter int TIMER_BITS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_write,
	input  wire [hdsu_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire [hdsu_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                 tick_valid,
	output logic                                tick_ready,
	input  hdsu_pkg::tick_t                     tick,
	output logic                                result_valid,
	input  wire                                 result_ready,
	output hdsu_pkg::result_t                   result
);

	localparam int CW = (TIMER_BITS > hdsu_pkg::CFG_DATA_W) ? TIMER_BITS
	                                                        : hdsu_pkg::CFG_DATA_W;
	localparam logic [CW-1:0] TIMER_MAX = CW'({TIMER_BITS{1'b1}});

	localparam logic       RX_IDLE  = 1'b0;
	localparam logic       RX_FRAME = 1'b1;
	localparam logic [2:0] TX_IDLE  = 3'd0;
	localparam logic [2:0] TX_START = 3'd1;
	localparam logic [2:0] TX_DATA  = 3'd2;
	localparam logic [2:0] TX_STOP  = 3'd3;
	localparam logic [2:0] TX_GUARD = 3'd4;

	function automatic logic [TIMER_BITS-1:0] load_value(
		input logic [hdsu_pkg::CFG_DATA_W-1:0] v
	);
		logic [CW-1:0] ext;
		ext = CW'(v);
		if (ext == '0)
			ext = CW'(1);
		if (ext > TIMER_MAX)
			ext = TIMER_MAX;
		return ext[TIMER_BITS-1:0];
	endfunction

	logic [hdsu_pkg::CFG_DATA_W-1:0] bit_period_q, first_sample_q;
	logic [hdsu_pkg::GUARD_W-1:0]    guard_bits_q;

	logic                            rx_phase_q, rx_phase_d;
	logic [3:0]                      rx_cnt_q, rx_cnt_d;
	logic [hdsu_pkg::DATA_W-1:0]     rx_shift_q, rx_shift_d;
	logic [hdsu_pkg::DATA_W-1:0]     rx_hold_q, rx_hold_d;
	logic                            rx_full_q, rx_full_d;
	logic [TIMER_BITS-1:0]           rx_timer_q, rx_timer_d;
	logic [2:0]                      tx_phase_q, tx_phase_d;
	logic [5:0]                      tx_cnt_q, tx_cnt_d;
	logic [hdsu_pkg::DATA_W-1:0]     tx_shift_q, tx_shift_d;
	logic [TIMER_BITS-1:0]           tx_timer_q, tx_timer_d;

	hdsu_pkg::result_t               result_d;
	logic                            take;

	assign tick_ready = !result_valid || result_ready;
	assign take       = tick_valid && tick_ready;

	always_comb begin
		rx_phase_d = rx_phase_q;
		rx_cnt_d   = rx_cnt_q;
		rx_shift_d = rx_shift_q;
		rx_hold_d  = rx_hold_q;
		rx_full_d  = rx_full_q;
		rx_timer_d = rx_timer_q;
		tx_phase_d = tx_phase_q;
		tx_cnt_d   = tx_cnt_q;
		tx_shift_d = tx_shift_q;
		tx_timer_d = tx_timer_q;
		result_d   = '0;

		result_d.rx_ready = rx_full_q;
		result_d.rx_data  = rx_hold_q;

		if (tick.read_request) begin
			rx_hold_d = '0;
			rx_full_d = 1'b0;
		end

		// transmitter
		unique case (tx_phase_q)
			TX_START: begin
				tx_timer_d = tx_timer_q - 1'b1;
				if (tx_timer_d == '0) begin
					tx_phase_d = TX_DATA;
					tx_cnt_d   = '0;
					tx_timer_d = load_value(bit_period_q);
				end
			end
			TX_DATA: begin
				tx_timer_d = tx_timer_q - 1'b1;
				if (tx_timer_d == '0) begin
					if (tx_cnt_q >= hdsu_pkg::TX_LAST_BIT) begin
						tx_phase_d = TX_STOP;
					end else begin
						tx_cnt_d   = tx_cnt_q + 1'b1;
						tx_shift_d = tx_shift_q >> 1;
						tx_timer_d = load_value(bit_period_q);
					end
				end
			end
			TX_STOP: begin
				if (guard_bits_q == '0) begin
					tx_phase_d = TX_IDLE;
					tx_cnt_d   = '0;
				end else begin
					tx_phase_d = TX_GUARD;
					tx_cnt_d   = guard_bits_q;
					tx_timer_d = load_value(bit_period_q);
				end
			end
			TX_GUARD: begin
				tx_timer_d = tx_timer_q - 1'b1;
				if (tx_timer_d == '0) begin
					tx_cnt_d = tx_cnt_q - 1'b1;
					if (tx_cnt_d == '0)
						tx_phase_d = TX_IDLE;
					else
						tx_timer_d = load_value(bit_period_q);
				end
			end
			default: begin
				tx_phase_d = TX_IDLE;
				if (tick.send_request && rx_phase_q == RX_IDLE) begin
					result_d.send_accepted = 1'b1;
					tx_phase_d = TX_START;
					tx_shift_d = tick.send_data;
					tx_cnt_d   = '0;
					tx_timer_d = load_value(bit_period_q);
				end
			end
		endcase

		// receiver
		unique case (rx_phase_q)
			RX_FRAME: begin
				rx_timer_d = rx_timer_q - 1'b1;
				if (rx_timer_d == '0) begin
					if (rx_cnt_q < hdsu_pkg::RX_STOP_SLOT) begin
						rx_shift_d[rx_cnt_q[2:0]] = tick.line_in;
						rx_cnt_d   = rx_cnt_q + 1'b1;
						rx_timer_d = load_value(bit_period_q);
					end else begin
						if (tick.line_in && !rx_full_d) begin
							rx_hold_d = rx_shift_q;
							rx_full_d = 1'b1;
						end
						rx_phase_d = RX_IDLE;
						rx_cnt_d   = '0;
					end
				end
			end
			default: begin
				if (tx_phase_d == TX_IDLE && !tick.line_in) begin
					rx_phase_d = RX_FRAME;
					rx_cnt_d   = '0;
					rx_timer_d = load_value(first_sample_q);
				end
			end
		endcase

		case (tx_phase_d)
			TX_START: result_d.line_drive = 1'b1;
			TX_DATA: begin
				result_d.line_drive = 1'b1;
				result_d.line_level = tx_shift_d[0];
			end
			TX_STOP: begin
				result_d.line_drive = 1'b1;
				result_d.line_level = 1'b1;
			end
			default: ;
		endcase

		result_d.link_busy = (tx_phase_d != TX_IDLE) || (rx_phase_d != RX_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q   <= hdsu_pkg::BIT_PERIOD_RST;
			first_sample_q <= hdsu_pkg::FIRST_SAMPLE_RST;
			guard_bits_q   <= hdsu_pkg::GUARD_BITS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				hdsu_pkg::REG_BIT_PERIOD:   bit_period_q <= cfg_data;
				hdsu_pkg::REG_FIRST_SAMPLE: first_sample_q <= cfg_data;
				hdsu_pkg::REG_GUARD_BITS:   guard_bits_q <= cfg_data[hdsu_pkg::GUARD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q <= RX_IDLE;
			rx_cnt_q   <= '0;
			rx_shift_q <= '0;
			rx_hold_q  <= '0;
			rx_full_q  <= 1'b0;
			rx_timer_q <= '0;
			tx_phase_q <= TX_IDLE;
			tx_cnt_q   <= '0;
			tx_shift_q <= '0;
			tx_timer_q <= '0;
		end else if (take) begin
			rx_phase_q <= rx_phase_d;
			rx_cnt_q   <= rx_cnt_d;
			rx_shift_q <= rx_shift_d;
			rx_hold_q  <= rx_hold_d;
			rx_full_q  <= rx_full_d;
			rx_timer_q <= rx_timer_d;
			tx_phase_q <= tx_phase_d;
			tx_cnt_q   <= tx_cnt_d;
			tx_shift_q <= tx_shift_d;
			tx_timer_q <= tx_timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (take)
			result_valid <= 1'b1;
		else if (result_ready)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			result <= result_d;
	end

	// transmitter and receiver never active together
	a_half_duplex: assert property (@(posedge clk) disable iff (!arst_n)
		!((tx_phase_q != TX_IDLE) && (rx_phase_q == RX_FRAME)))
		else $error("tx and rx frames overlap");

	// an accepted send shows the start bit on its own result beat
	a_start_bit: assert property (@(posedge clk) disable iff (!arst_n)
		take && result_d.send_accepted |=>
			result_valid && result.line_drive && !result.line_level)
		else $error("accepted send without start bit");

	// a taken tick always leaves a result beat behind
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> result_valid)
		else $error("tick beat produced no result");

endmodule
`default_nettype wire

// ----- tb/half_duplex_soft_uart_tb.sv -----
// Self-checking testbench for the half-duplex single-wire UART with a built-in line predictor.
`timescale 1ns / 100ps
module half_duplex_soft_uart_tb;

	typedef enum logic [2:0] {TX_IDLE, TX_START, TX_DATA, TX_STOP, TX_GUARD} tx_state_e;
	typedef enum logic {RX_IDLE, RX_FRAME} rx_state_e;

	localparam logic [hdsu_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_write = 1'b0;
	logic [hdsu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [hdsu_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                             tick_valid = 1'b0;
	logic                             tick_ready;
	hdsu_pkg::tick_t                  tick_in = '0;
	logic                             result_valid;
	logic                             result_ready = 1'b0;
	hdsu_pkg::result_t                result_out;

	half_duplex_soft_uart uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick_valid(tick_valid),
		.tick_ready(tick_ready),
		.tick(tick_in),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result_out)
	);

	// timing registers as the block should hold them
	logic [hdsu_pkg::CFG_DATA_W-1:0] cfg_period = hdsu_pkg::BIT_PERIOD_RST;
	logic [hdsu_pkg::CFG_DATA_W-1:0] cfg_first  = hdsu_pkg::FIRST_SAMPLE_RST;
	logic [hdsu_pkg::GUARD_W-1:0]    cfg_guard  = hdsu_pkg::GUARD_BITS_RST;

	// predicted link state
	rx_state_e   rx_state = RX_IDLE;
	logic [3:0]  rx_count = '0;
	logic [7:0]  rx_shift = '0;
	logic [7:0]  rx_hold  = '0;
	logic        rx_full  = 1'b0;
	logic [15:0] rx_timer = '0;
	tx_state_e   tx_state = TX_IDLE;
	logic [5:0]  tx_count = '0;
	logic [7:0]  tx_shift = '0;
	logic [15:0] tx_timer = '0;

	hdsu_pkg::tick_t   pending_ticks[$];
	hdsu_pkg::result_t expected_results[$];
	int unsigned pushed_total = 0;
	int          accepted_ticks = 0;
	int          results_seen = 0;
	int          hold_left = 0;
	bit          held_once = 1'b0;
	int          fail_count = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [15:0] reload(logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	function automatic hdsu_pkg::result_t step_uart(hdsu_pkg::tick_t t);
		hdsu_pkg::result_t r;
		r = '0;
		r.rx_ready = rx_full;
		r.rx_data = rx_hold;
		if (t.read_request) begin
			rx_hold = '0;
			rx_full = 1'b0;
		end

		case (tx_state)
			TX_START: begin
				tx_timer = tx_timer - 16'd1;
				if (tx_timer == 16'd0) begin
					tx_state = TX_DATA;
					tx_count = '0;
					tx_timer = reload(cfg_period);
				end
			end
			TX_DATA: begin
				tx_timer = tx_timer - 16'd1;
				if (tx_timer == 16'd0) begin
					if (tx_count >= hdsu_pkg::TX_LAST_BIT) begin
						tx_state = TX_STOP;
					end else begin
						tx_count = tx_count + 6'd1;
						tx_shift = tx_shift >> 1;
						tx_timer = reload(cfg_period);
					end
				end
			end
			TX_STOP: begin
				if (cfg_guard == '0) begin
					tx_state = TX_IDLE;
					tx_count = '0;
				end else begin
					tx_state = TX_GUARD;
					tx_count = cfg_guard;
					tx_timer = reload(cfg_period);
				end
			end
			TX_GUARD: begin
				tx_timer = tx_timer - 16'd1;
				if (tx_timer == 16'd0) begin
					tx_count = tx_count - 6'd1;
					if (tx_count == '0)
						tx_state = TX_IDLE;
					else
						tx_timer = reload(cfg_period);
				end
			end
			default: begin
				if (t.send_request && rx_state == RX_IDLE) begin
					r.send_accepted = 1'b1;
					tx_state = TX_START;
					tx_shift = t.send_data;
					tx_count = '0;
					tx_timer = reload(cfg_period);
				end
			end
		endcase

		if (rx_state == RX_FRAME) begin
			rx_timer = rx_timer - 16'd1;
			if (rx_timer == 16'd0) begin
				if (rx_count < hdsu_pkg::RX_STOP_SLOT) begin
					rx_shift[rx_count[2:0]] = t.line_in;
					rx_count = rx_count + 4'd1;
					rx_timer = reload(cfg_period);
				end else begin
					if (t.line_in && !rx_full) begin
						rx_hold = rx_shift;
						rx_full = 1'b1;
					end
					rx_state = RX_IDLE;
					rx_count = '0;
				end
			end
		end else if (tx_state == TX_IDLE && !t.line_in) begin
			rx_state = RX_FRAME;
			rx_count = '0;
			rx_timer = reload(cfg_first);
		end

		case (tx_state)
			TX_START: r.line_drive = 1'b1;
			TX_DATA: begin
				r.line_drive = 1'b1;
				r.line_level = tx_shift[0];
			end
			TX_STOP: begin
				r.line_drive = 1'b1;
				r.line_level = 1'b1;
			end
			default: ;
		endcase
		r.link_busy = (tx_state != TX_IDLE) || (rx_state != RX_IDLE);
		return r;
	endfunction

	task automatic check_result(hdsu_pkg::result_t want, hdsu_pkg::result_t got);
		if (got.line_drive !== want.line_drive) begin
			$error("line_drive: expected %0d, actual %0d", want.line_drive, got.line_drive);
			fail_count++;
		end
		if (got.line_level !== want.line_level) begin
			$error("line_level: expected %0d, actual %0d", want.line_level, got.line_level);
			fail_count++;
		end
		if (got.rx_ready !== want.rx_ready) begin
			$error("rx_ready: expected %0d, actual %0d", want.rx_ready, got.rx_ready);
			fail_count++;
		end
		if (got.rx_data !== want.rx_data) begin
			$error("rx_data: expected %02h, actual %02h", want.rx_data, got.rx_data);
			fail_count++;
		end
		if (got.send_accepted !== want.send_accepted) begin
			$error("send_accepted: expected %0d, actual %0d", want.send_accepted,
				got.send_accepted);
			fail_count++;
		end
		if (got.link_busy !== want.link_busy) begin
			$error("link_busy: expected %0d, actual %0d", want.link_busy, got.link_busy);
			fail_count++;
		end
	endtask

	// tick driver, predictor runs on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
			tick_in <= '0;
			accepted_ticks <= 0;
		end else begin
			if (tick_valid && tick_ready) begin
				expected_results.push_back(step_uart(tick_in));
				accepted_ticks <= accepted_ticks + 1;
			end
			if (!tick_valid || tick_ready) begin
				if (pending_ticks.size() != 0 && ((accepted_ticks >= 400 && accepted_ticks < 700)
						|| $urandom_range(99) >= 12)) begin
					tick_valid <= 1'b1;
					tick_in <= pending_ticks.pop_front();
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_left <= 0;
			held_once <= 1'b0;
			results_seen <= 0;
		end else begin
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("result beat with no expected result pending");
					fail_count++;
				end else begin
					check_result(expected_results.pop_front(), result_out);
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (!held_once && results_seen == 300) begin
				held_once <= 1'b1;
				hold_left <= 200;
				result_ready <= 1'b0;
			end else begin
				result_ready <= (results_seen >= 400 && results_seen < 700)
					|| $urandom_range(99) >= 12;
			end
		end
	end

	function automatic void add_tick(bit line, bit send, logic [7:0] data, bit rd);
		hdsu_pkg::tick_t t;
		t.line_in = line;
		t.send_request = send;
		t.send_data = data;
		t.read_request = rd;
		pending_ticks.push_back(t);
		pushed_total++;
	endfunction

	function automatic bit rand_read();
		return $urandom_range(99) < 8;
	endfunction

	// start bit, 8 data bits LSB first, stop bit; each bit one period long
	function automatic void queue_frame(logic [7:0] data, bit stop_high, bit read_on_stop);
		int unsigned per;
		per = 32'(reload(cfg_period));
		for (int k = 0; k < 10; k++) begin
			bit lvl;
			lvl = (k == 0) ? 1'b0 : (k == 9) ? stop_high : data[k-1];
			for (int j = 0; j < per; j++)
				add_tick(lvl, 1'b0, 8'($urandom),
					(read_on_stop && k == 9 && j == per / 2) ? 1'b1 : rand_read());
		end
	endfunction

	task automatic wait_drained();
		while (pending_ticks.size() != 0 || tick_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// feed quiet line until the link is idle again, then let it settle
	task automatic settle_link();
		do begin
			wait_drained();
			if (tx_state != TX_IDLE || rx_state != RX_IDLE)
				repeat (16) add_tick(1'b1, 1'b0, 8'($urandom), rand_read());
		end while (pending_ticks.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(logic [hdsu_pkg::CFG_INDEX_W-1:0] idx,
			logic [hdsu_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			hdsu_pkg::REG_BIT_PERIOD: cfg_period = value;
			hdsu_pkg::REG_FIRST_SAMPLE: cfg_first = value;
			hdsu_pkg::REG_GUARD_BITS: cfg_guard = value[hdsu_pkg::GUARD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(logic [15:0] per, logic [15:0] first, logic [5:0] guard);
		settle_link();
		write_reg(hdsu_pkg::REG_BIT_PERIOD, per);
		write_reg(hdsu_pkg::REG_FIRST_SAMPLE, first);
		write_reg(hdsu_pkg::REG_GUARD_BITS, {10'd0, guard});
		@(negedge clk);
	endtask

	task automatic run_random(int unsigned count);
		int unsigned stop_at;
		int unsigned per;
		int unsigned pick;
		int unsigned span;
		stop_at = pushed_total + count;
		per = 32'(reload(cfg_period));
		while (pushed_total < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				queue_frame(8'($urandom), $urandom_range(99) < 85, $urandom_range(99) < 10);
				repeat ($urandom_range(per, 0))
					add_tick(1'b1, 1'b0, 8'($urandom), rand_read());
			end else if (pick < 75) begin
				add_tick(1'($urandom), 1'b1, 8'($urandom), rand_read());
				span = 10 * per + 32'(cfg_guard) * per + 2;
				repeat (span)
					add_tick(1'($urandom), $urandom_range(99) < 5, 8'($urandom), rand_read());
				add_tick(1'b1, 1'b0, 8'($urandom), 1'b0);
			end else begin
				span = $urandom_range(3 * per, 1);
				repeat (span)
					add_tick(1'($urandom), $urandom_range(99) < 3, 8'($urandom), rand_read());
			end
		end
	endtask

	int unsigned mode_period[7] = '{1, 2, 4, 3, 5, 16, 2};
	int unsigned mode_first[7]  = '{2, 3, 6, 1, 8, 24, 3};
	int unsigned mode_guard[7]  = '{1, 63, 3, 0, 7, 20, 2};
	int unsigned mode_ticks[7]  = '{120, 120, 120, 100, 100, 120, 40};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(REG_UNUSED, 16'hFFFF);
		set_timing(16'd0, 16'd0, 6'd0);

		add_tick(1'b1, 1'b0, 8'h00, 1'b1);       // read with empty buffer
		queue_frame(8'hFF, 1'b1, 1'b0);
		queue_frame(8'h00, 1'b1, 1'b1);          // read clears as the new byte lands
		queue_frame(8'hA5, 1'b0, 1'b0);          // low stop bit, dropped
		add_tick(1'b1, 1'b0, 8'h00, 1'b1);
		add_tick(1'b0, 1'b1, 8'h00, 1'b0);       // send and start bit together
		repeat (10) add_tick(1'b1, 1'b1, 8'hFF, 1'b0);  // sends while busy
		add_tick(1'b1, 1'b1, 8'hFF, 1'b0);
		repeat (11) add_tick(1'b1, 1'b0, 8'h00, 1'b0);

		for (int m = 0; m < 7; m++) begin
			set_timing(16'(mode_period[m]), 16'(mode_first[m]), 6'(mode_guard[m]));
			run_random(mode_ticks[m]);
		end

		// slowest bit period: quiet line only
		set_timing(16'hFFFF, 16'd2, 6'd0);
		repeat (30) add_tick(1'b1, 1'b0, 8'($urandom), $urandom_range(99) < 30);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
